>>> hw/rtl/ksq_pkg.sv
// Package for the key scancode translator: sizes, request codes, transaction types, code tables.
`default_nettype none

package ksq_pkg;

	localparam int QUEUE_DEPTH = 32;
	localparam int KEY_COUNT   = 256;
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
	localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);
	localparam int KEY_W       = $clog2(KEY_COUNT);
	localparam int EVT_W       = 9;
	localparam int KWORD_W     = 2;

	typedef enum logic [1:0] {
		REQ_SAMPLE = 2'd0,
		REQ_EXT    = 2'd1,
		REQ_POP    = 2'd2,
		REQ_NONE   = 2'd3
	} req_type_t;

	typedef struct packed {
		logic [1:0] req_type;
		logic [7:0] key_index;
		logic       key_down;
		logic       latin_layout;
		logic [7:0] ext_code;
	} req_item_t;

	typedef struct packed {
		logic       event_valid;
		logic [7:0] event_code;
		logic       event_pressed;
		logic [5:0] events_waiting;
	} evt_item_t;

	// Translate a host key index to a machine key code in the chosen layout.
	function automatic logic [7:0] key_code(input logic [7:0] idx, input logic latin);
		logic [7:0] code;
		code = 8'd0;
		case (idx)
			8'd8:   code = 8'o132;
			8'd9:   code = 8'o026;
			8'd13:  code = 8'o153;
			8'd14:  code = 8'o166;
			8'd16:  code = 8'o105;
			8'd20:  code = 8'o107;
			8'd27:  code = 8'o006;
			8'd32:  code = 8'o113;
			8'd33:  code = 8'o004;
			8'd34:  code = 8'o151;
			8'd35:  code = 8'o152;
			8'd36:  code = latin ? 8'o155 : 8'o174;
			8'd37:  code = 8'o116;
			8'd38:  code = 8'o154;
			8'd39:  code = 8'o133;
			8'd40:  code = 8'o134;
			8'd45:  code = 8'o171;
			8'd46:  code = 8'o172;
			8'd48:  code = 8'o176;
			8'd49:  code = 8'o030;
			8'd50:  code = 8'o031;
			8'd51:  code = 8'o032;
			8'd52:  code = 8'o013;
			8'd53:  code = 8'o034;
			8'd54:  code = 8'o035;
			8'd55:  code = 8'o016;
			8'd56:  code = 8'o017;
			8'd57:  code = 8'o177;
			8'd65:  code = latin ? 8'o072 : 8'o047;
			8'd66:  code = latin ? 8'o076 : 8'o073;
			8'd67:  code = latin ? 8'o050 : 8'o111;
			8'd68:  code = latin ? 8'o057 : 8'o071;
			8'd69:  code = latin ? 8'o033 : 8'o051;
			8'd70:  code = latin ? 8'o047 : 8'o072;
			8'd71:  code = latin ? 8'o055 : 8'o053;
			8'd72:  code = latin ? 8'o156 : 8'o074;
			8'd73:  code = latin ? 8'o073 : 8'o036;
			8'd74:  code = latin ? 8'o027 : 8'o075;
			8'd75:  code = latin ? 8'o052 : 8'o056;
			8'd76:  code = latin ? 8'o056 : 8'o057;
			8'd77:  code = latin ? 8'o112 : 8'o115;
			8'd78:  code = latin ? 8'o054 : 8'o114;
			8'd79:  code = latin ? 8'o075 : 8'o037;
			8'd80:  code = latin ? 8'o053 : 8'o157;
			8'd81:  code = latin ? 8'o067 : 8'o027;
			8'd82:  code = latin ? 8'o074 : 8'o052;
			8'd83:  code = latin ? 8'o111 : 8'o070;
			8'd84:  code = latin ? 8'o114 : 8'o033;
			8'd85:  code = latin ? 8'o051 : 8'o055;
			8'd86:  code = latin ? 8'o137 : 8'o112;
			8'd87:  code = latin ? 8'o071 : 8'o050;
			8'd88:  code = latin ? 8'o115 : 8'o110;
			8'd89:  code = latin ? 8'o070 : 8'o054;
			8'd90:  code = latin ? 8'o157 : 8'o067;
			8'd93:  code = 8'o106;
			8'd96:  code = 8'o126;
			8'd97:  code = 8'o127;
			8'd98:  code = 8'o147;
			8'd99:  code = 8'o167;
			8'd100: code = 8'o130;
			8'd101: code = 8'o150;
			8'd102: code = 8'o170;
			8'd103: code = 8'o125;
			8'd104: code = 8'o145;
			8'd105: code = 8'o165;
			8'd106: code = 8'o025;
			8'd109: code = 8'o005;
			8'd110: code = 8'o146;
			8'd111: code = 8'o131;
			8'd112: code = 8'o010;
			8'd113: code = 8'o011;
			8'd114: code = 8'o012;
			8'd115: code = 8'o014;
			8'd116: code = 8'o015;
			8'd117: code = 8'o172;
			8'd118: code = 8'o152;
			8'd119: code = 8'o151;
			8'd120: code = 8'o171;
			8'd122: code = 8'o004;
			8'd123: code = latin ? 8'o155 : 8'o174;
			8'd162: code = 8'o046;
			8'd163: code = 8'o066;
			8'd186: code = latin ? 8'o174 : 8'o137;
			8'd187: code = latin ? 8'o110 : 8'o117;
			8'd188: code = latin ? 8'o117 : 8'o076;
			8'd189: code = 8'o175;
			8'd190: code = latin ? 8'o135 : 8'o077;
			8'd191: code = 8'o173;
			8'd192: code = 8'o007;
			8'd219: code = latin ? 8'o036 : 8'o156;
			8'd220: code = latin ? 8'o136 : 8'o135;
			8'd221: code = latin ? 8'o037 : 8'o155;
			8'd222: code = latin ? 8'o077 : 8'o136;
			default: code = 8'd0;
		endcase
		return code;
	endfunction

endpackage

`default_nettype wire

>>> hw/rtl/ksq_ram.sv
// Generic single-clock RAM: one write port, one registered read port, read-first.
`default_nettype none

module ksq_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 32
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Write and read; a same-address read returns the old word.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

`default_nettype wire

>>> hw/rtl/key_scancode_translate_queue_top.sv
// Key scancode translator: per-key store, layout tables and event FIFO.
// Throughput: one transaction of any type per cycle, unless a pop waits on a stalled result.
// A pop passes the stage-1 register, then its FIFO word and status are registered into stage 2;
// it waits in stage 1 while a result is stalled. The per-key store read and the FIFO read
// are both synchronous RAM reads.
// Reset clears the per-key valid bits, FIFO pointers and count at once;
// no clearing pass is needed and requests are taken right after reset.
`default_nettype none

module key_scancode_translate_queue_top
	import ksq_pkg::*;
(
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      req_valid,
	output logic           req_stall,
	input  wire req_item_t req,
	output logic           evt_valid,
	input  wire logic      evt_stall,
	output evt_item_t      evt
);

	// Stage 1 and stage 2 registers
	logic                valid_s1;
	req_item_t           item_s1;
	logic                fwd_hit_s1;
	logic [KWORD_W-1:0]  fwd_data_s1;
	logic                kvld_s1;
	logic                valid_s2;
	logic                hit_s2;
	logic [QCNT_W-1:0]   wait_s2;

	// FIFO control and key valid bits
	logic [QPTR_W-1:0]   wr_ptr_q;
	logic [QPTR_W-1:0]   rd_ptr_q;
	logic [QCNT_W-1:0]   count_q;
	logic [KEY_COUNT-1:0] key_vld_q;

	logic                accept;
	logic                s1_pop;
	logic                s1_go;
	logic                s2_free;
	logic                is_sample;
	logic                is_ext;
	logic [KWORD_W-1:0]  key_rdata;
	logic [KWORD_W-1:0]  key_word;
	logic                changed;
	logic                use_lat;
	logic [7:0]          code;
	logic                key_we;
	logic [KWORD_W-1:0]  key_wdata;
	logic                push_req;
	logic [7:0]          push_code;
	logic                full;
	logic                empty;
	logic                do_push;
	logic                do_pop;
	logic [EVT_W-1:0]    fifo_rdata;

	// Handshake: stage 1 holds only a pop waiting on a stalled result
	assign s2_free   = !valid_s2 || !evt_stall;
	assign s1_pop    = item_s1.req_type == REQ_POP;
	assign s1_go     = valid_s1 && (!s1_pop || s2_free);
	assign req_stall = valid_s1 && !s1_go;
	assign accept    = req_valid && !req_stall;

	// Resolve the key word: forwarded write, stored word, or reset value
	always_comb begin
		if (fwd_hit_s1) begin
			key_word = fwd_data_s1;
		end else if (kvld_s1) begin
			key_word = key_rdata;
		end else begin
			key_word = '0;
		end
	end

	// Translate a key change and decide on a push
	assign is_sample = item_s1.req_type == REQ_SAMPLE;
	assign is_ext    = item_s1.req_type == REQ_EXT;
	assign changed   = item_s1.key_down != key_word[0];
	assign use_lat   = key_word[0] ? key_word[1] : item_s1.latin_layout;
	assign code      = key_code(item_s1.key_index, use_lat);
	assign key_we    = s1_go && is_sample && changed;
	assign key_wdata = {item_s1.key_down & item_s1.latin_layout, item_s1.key_down};
	assign push_req  = (is_sample && changed && (code != 8'd0)) || is_ext;
	assign push_code = is_ext ? item_s1.ext_code : code;
	assign full      = count_q == QCNT_W'(QUEUE_DEPTH);
	assign empty     = count_q == '0;
	assign do_push   = s1_go && push_req && !full;
	assign do_pop    = s1_go && s1_pop && !empty;

	ksq_ram #(
		.WIDTH (KWORD_W),
		.DEPTH (KEY_COUNT)
	) u_key_ram (
		.clk   (clk),
		.we    (key_we),
		.waddr (item_s1.key_index[KEY_W-1:0]),
		.wdata (key_wdata),
		.re    (accept),
		.raddr (req.key_index[KEY_W-1:0]),
		.rdata (key_rdata)
	);

	ksq_ram #(
		.WIDTH (EVT_W),
		.DEPTH (QUEUE_DEPTH)
	) u_fifo_ram (
		.clk   (clk),
		.we    (do_push),
		.waddr (wr_ptr_q),
		.wdata ({item_s1.key_down, push_code}),
		.re    (do_pop),
		.raddr (rd_ptr_q),
		.rdata (fifo_rdata)
	);

	// Control state: stage valids, pointers, count, key valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1  <= 1'b0;
			valid_s2  <= 1'b0;
			wr_ptr_q  <= '0;
			rd_ptr_q  <= '0;
			count_q   <= '0;
			key_vld_q <= '0;
		end else begin
			if (accept) begin
				valid_s1 <= 1'b1;
			end else if (s1_go) begin
				valid_s1 <= 1'b0;
			end
			if (s1_go && s1_pop) begin
				valid_s2 <= 1'b1;
			end else if (!evt_stall) begin
				valid_s2 <= 1'b0;
			end
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
				count_q  <= count_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
				count_q  <= count_q - 1'b1;
			end
			if (key_we) begin
				key_vld_q[item_s1.key_index[KEY_W-1:0]] <= 1'b1;
			end
		end
	end

	// Payload registers: capture the transaction, forward a same-key write and hold the pop status
	always_ff @(posedge clk) begin
		if (accept) begin
			item_s1     <= req;
			kvld_s1     <= key_vld_q[req.key_index[KEY_W-1:0]];
			fwd_hit_s1  <= key_we && (item_s1.key_index == req.key_index);
			fwd_data_s1 <= key_wdata;
		end
		if (s1_go && s1_pop) begin
			hit_s2  <= !empty;
			wait_s2 <= empty ? '0 : count_q - 1'b1;
		end
	end

	// Present the pop result
	assign evt_valid            = valid_s2;
	assign evt.event_valid      = hit_s2;
	assign evt.event_code       = hit_s2 ? fifo_rdata[7:0] : 8'd0;
	assign evt.event_pressed    = hit_s2 ? fifo_rdata[8] : 1'b0;
	assign evt.events_waiting   = 6'(wait_s2);

endmodule

`default_nettype wire

>>> verif/key_scancode_translate_queue_top_test.sv
// Testbench for the key scancode translator: directed and random requests, local predictor.
`default_nettype none

module key_scancode_translate_queue_top_test;
	import ksq_pkg::*;

	localparam int CYCLE_LIMIT = 200000;
	localparam int PHASE_ITEMS = 350;

	// Predict popped events from key samples, external events and pops
	class key_event_tracker;
		logic [7:0] lat_tbl [256];
		logic [7:0] rus_tbl [256];
		bit         key_state [256];
		bit         key_latin [256];
		logic [8:0] queued_events [$];
		evt_item_t  events_due [$];
		int         mismatches;

		function new();
			for (int i = 0; i < 256; i++) begin
				lat_tbl[i] = 8'd0;
				rus_tbl[i] = 8'd0;
				key_state[i] = 1'b0;
				key_latin[i] = 1'b0;
			end
			mismatches = 0;
			set_code(8, 8'o132, 8'o132);
			set_code(9, 8'o026, 8'o026);
			set_code(13, 8'o153, 8'o153);
			set_code(14, 8'o166, 8'o166);
			set_code(16, 8'o105, 8'o105);
			set_code(20, 8'o107, 8'o107);
			set_code(27, 8'o006, 8'o006);
			set_code(32, 8'o113, 8'o113);
			set_code(33, 8'o004, 8'o004);
			set_code(34, 8'o151, 8'o151);
			set_code(35, 8'o152, 8'o152);
			set_code(36, 8'o155, 8'o174);
			set_code(37, 8'o116, 8'o116);
			set_code(38, 8'o154, 8'o154);
			set_code(39, 8'o133, 8'o133);
			set_code(40, 8'o134, 8'o134);
			set_code(45, 8'o171, 8'o171);
			set_code(46, 8'o172, 8'o172);
			set_code(48, 8'o176, 8'o176);
			set_code(49, 8'o030, 8'o030);
			set_code(50, 8'o031, 8'o031);
			set_code(51, 8'o032, 8'o032);
			set_code(52, 8'o013, 8'o013);
			set_code(53, 8'o034, 8'o034);
			set_code(54, 8'o035, 8'o035);
			set_code(55, 8'o016, 8'o016);
			set_code(56, 8'o017, 8'o017);
			set_code(57, 8'o177, 8'o177);
			// letter keys differ between the layouts
			set_code(65, 8'o072, 8'o047);
			set_code(66, 8'o076, 8'o073);
			set_code(67, 8'o050, 8'o111);
			set_code(68, 8'o057, 8'o071);
			set_code(69, 8'o033, 8'o051);
			set_code(70, 8'o047, 8'o072);
			set_code(71, 8'o055, 8'o053);
			set_code(72, 8'o156, 8'o074);
			set_code(73, 8'o073, 8'o036);
			set_code(74, 8'o027, 8'o075);
			set_code(75, 8'o052, 8'o056);
			set_code(76, 8'o056, 8'o057);
			set_code(77, 8'o112, 8'o115);
			set_code(78, 8'o054, 8'o114);
			set_code(79, 8'o075, 8'o037);
			set_code(80, 8'o053, 8'o157);
			set_code(81, 8'o067, 8'o027);
			set_code(82, 8'o074, 8'o052);
			set_code(83, 8'o111, 8'o070);
			set_code(84, 8'o114, 8'o033);
			set_code(85, 8'o051, 8'o055);
			set_code(86, 8'o137, 8'o112);
			set_code(87, 8'o071, 8'o050);
			set_code(88, 8'o115, 8'o110);
			set_code(89, 8'o070, 8'o054);
			set_code(90, 8'o157, 8'o067);
			set_code(93, 8'o106, 8'o106);
			set_code(96, 8'o126, 8'o126);
			set_code(97, 8'o127, 8'o127);
			set_code(98, 8'o147, 8'o147);
			set_code(99, 8'o167, 8'o167);
			set_code(100, 8'o130, 8'o130);
			set_code(101, 8'o150, 8'o150);
			set_code(102, 8'o170, 8'o170);
			set_code(103, 8'o125, 8'o125);
			set_code(104, 8'o145, 8'o145);
			set_code(105, 8'o165, 8'o165);
			set_code(106, 8'o025, 8'o025);
			set_code(109, 8'o005, 8'o005);
			set_code(110, 8'o146, 8'o146);
			set_code(111, 8'o131, 8'o131);
			set_code(112, 8'o010, 8'o010);
			set_code(113, 8'o011, 8'o011);
			set_code(114, 8'o012, 8'o012);
			set_code(115, 8'o014, 8'o014);
			set_code(116, 8'o015, 8'o015);
			set_code(117, 8'o172, 8'o172);
			set_code(118, 8'o152, 8'o152);
			set_code(119, 8'o151, 8'o151);
			set_code(120, 8'o171, 8'o171);
			set_code(122, 8'o004, 8'o004);
			set_code(123, 8'o155, 8'o174);
			set_code(162, 8'o046, 8'o046);
			set_code(163, 8'o066, 8'o066);
			set_code(186, 8'o174, 8'o137);
			set_code(187, 8'o110, 8'o117);
			set_code(188, 8'o117, 8'o076);
			set_code(189, 8'o175, 8'o175);
			set_code(190, 8'o135, 8'o077);
			set_code(191, 8'o173, 8'o173);
			set_code(192, 8'o007, 8'o007);
			set_code(219, 8'o036, 8'o156);
			set_code(220, 8'o136, 8'o135);
			set_code(221, 8'o037, 8'o155);
			set_code(222, 8'o077, 8'o136);
		endfunction

		function void set_code(int idx, logic [7:0] lat, logic [7:0] rus);
			lat_tbl[idx] = lat;
			rus_tbl[idx] = rus;
		endfunction

		// Drop the event when the queue is full
		function void push_event(logic [7:0] code, logic pressed);
			if (queued_events.size() < QUEUE_DEPTH)
				queued_events.push_back({pressed, code});
		endfunction

		// Update the predicted state for one accepted request transaction
		function void take_request(req_item_t r);
			bit         use_latin;
			logic [7:0] code;
			logic [8:0] entry;
			evt_item_t  e;
			case (r.req_type)
				REQ_SAMPLE: begin
					if (r.key_down != key_state[r.key_index]) begin
						// release translates with the layout latched at press time
						use_latin = key_state[r.key_index] ? key_latin[r.key_index] : r.latin_layout;
						key_state[r.key_index] = r.key_down;
						key_latin[r.key_index] = r.key_down ? r.latin_layout : 1'b0;
						code = use_latin ? lat_tbl[r.key_index] : rus_tbl[r.key_index];
						if (code != 8'd0)
							push_event(code, r.key_down);
					end
				end
				REQ_EXT: begin
					push_event(r.ext_code, r.key_down);
				end
				REQ_POP: begin
					e = '0;
					if (queued_events.size() != 0) begin
						entry = queued_events.pop_front();
						e.event_valid = 1'b1;
						e.event_code = entry[7:0];
						e.event_pressed = entry[8];
						e.events_waiting = 6'(queued_events.size());
					end
					events_due.push_back(e);
				end
				default: ;
			endcase
		endfunction

		// Compare one accepted event transaction with the oldest prediction
		function void check_event(evt_item_t got);
			evt_item_t want;
			if (events_due.size() == 0) begin
				$display("%0t: unexpected event, got %h", $time, got);
				mismatches++;
				return;
			end
			want = events_due.pop_front();
			if (got.event_valid !== want.event_valid) begin
				$display("%0t: event_valid expected %0d got %0d", $time,
					want.event_valid, got.event_valid);
				mismatches++;
			end
			if (got.event_code !== want.event_code) begin
				$display("%0t: event_code expected %o got %o", $time,
					want.event_code, got.event_code);
				mismatches++;
			end
			if (got.event_pressed !== want.event_pressed) begin
				$display("%0t: event_pressed expected %0d got %0d", $time,
					want.event_pressed, got.event_pressed);
				mismatches++;
			end
			if (got.events_waiting !== want.events_waiting) begin
				$display("%0t: events_waiting expected %0d got %0d", $time,
					want.events_waiting, got.events_waiting);
				mismatches++;
			end
		endfunction
	endclass

	logic      clk = 1'b0;
	logic      arst_n = 1'b0;
	logic      req_valid = 1'b0;
	logic      req_stall;
	req_item_t req = '0;
	logic      evt_valid;
	logic      evt_stall = 1'b0;
	evt_item_t evt;

	int tx_idle_pct = 0;
	int rx_idle_pct = 0;
	int cycle_count = 0;

	key_event_tracker tracker = new();

	key_scancode_translate_queue_top dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req       (req),
		.evt_valid (evt_valid),
		.evt_stall (evt_stall),
		.evt       (evt)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Give up when the run takes far longer than any correct one
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("Some tests failed");
			$finish;
		end
	end

	// Stall the event side at random
	always @(posedge clk) begin
		evt_stall <= ($urandom_range(99) < rx_idle_pct);
	end

	// Check every accepted event transaction
	always @(posedge clk) begin
		if (arst_n && evt_valid && !evt_stall)
			tracker.check_event(evt);
	end

	function automatic req_item_t make_req(req_type_t t, logic [7:0] idx, logic down,
			logic latin, logic [7:0] ext);
		req_item_t r;
		r.req_type = t;
		r.key_index = idx;
		r.key_down = down;
		r.latin_layout = latin;
		r.ext_code = ext;
		return r;
	endfunction

	// Offer one request transaction, idling first at random, and hold it until taken
	task automatic send_request(input req_item_t r);
		while ($urandom_range(99) < tx_idle_pct) begin
			req_valid <= 1'b0;
			@(posedge clk);
		end
		req_valid <= 1'b1;
		req <= r;
		do @(posedge clk); while (req_stall);
		tracker.take_request(r);
	endtask

	initial begin
		req_item_t r;
		int        issued;
		int        pop_pct;
		int        roll;
		int        pick;

		repeat (7) @(posedge clk);
		arst_n <= 1'b1;

		// Directed: empty pop, layouts, latched release, zero codes, external codes
		tx_idle_pct = 15;
		rx_idle_pct = 75;
		send_request(make_req(REQ_POP, 8'd0, 1'b0, 1'b0, 8'd0));
		send_request(make_req(REQ_SAMPLE, 8'd8, 1'b1, 1'b1, 8'd0));
		send_request(make_req(REQ_SAMPLE, 8'd8, 1'b1, 1'b0, 8'd0));
		send_request(make_req(REQ_SAMPLE, 8'd36, 1'b1, 1'b1, 8'd0));
		send_request(make_req(REQ_SAMPLE, 8'd8, 1'b0, 1'b0, 8'd0));
		send_request(make_req(REQ_SAMPLE, 8'd36, 1'b0, 1'b0, 8'd0));
		send_request(make_req(REQ_SAMPLE, 8'd65, 1'b1, 1'b0, 8'd0));
		send_request(make_req(REQ_SAMPLE, 8'd65, 1'b0, 1'b1, 8'd0));
		send_request(make_req(REQ_SAMPLE, 8'd0, 1'b1, 1'b1, 8'd0));
		send_request(make_req(REQ_SAMPLE, 8'd255, 1'b1, 1'b0, 8'd255));
		send_request(make_req(REQ_SAMPLE, 8'd255, 1'b0, 1'b1, 8'd255));
		send_request(make_req(REQ_EXT, 8'd0, 1'b1, 1'b0, 8'd0));
		send_request(make_req(REQ_EXT, 8'd255, 1'b0, 1'b1, 8'd255));
		send_request(make_req(REQ_NONE, 8'd255, 1'b1, 1'b1, 8'd255));
		send_request(make_req(REQ_SAMPLE, 8'd222, 1'b1, 1'b1, 8'd0));
		send_request(make_req(REQ_SAMPLE, 8'd222, 1'b0, 1'b0, 8'd0));
		repeat (8)
			send_request(make_req(REQ_POP, 8'd255, 1'b1, 1'b1, 8'd255));

		// Random: blocks alternate between filling, draining and balanced traffic
		for (int phase = 0; phase < 3; phase++) begin
			tx_idle_pct = (phase == 0) ? 15 : (phase == 1) ? 75 : 0;
			rx_idle_pct = (phase == 0) ? 75 : (phase == 1) ? 15 : 0;
			issued = 0;
			pop_pct = 30;
			while (issued < PHASE_ITEMS) begin
				if (issued % 50 == 0) begin
					pick = $urandom_range(2);
					pop_pct = (pick == 0) ? 5 : (pick == 1) ? 30 : 60;
				end
				r.key_index = 8'($urandom_range(255));
				r.key_down = 1'($urandom_range(1));
				r.latin_layout = 1'($urandom_range(1));
				r.ext_code = 8'($urandom_range(255));
				roll = $urandom_range(99);
				if (roll < pop_pct) begin
					r.req_type = REQ_POP;
				end else if (roll < pop_pct + 4) begin
					r.req_type = REQ_NONE;
				end else if (roll < pop_pct + 19) begin
					r.req_type = REQ_EXT;
				end else begin
					r.req_type = REQ_SAMPLE;
					// favor keys with codes, and mostly toggle the key
					pick = $urandom_range(9);
					if (pick < 7)
						r.key_index = 8'($urandom_range(127, 32));
					else if (pick < 9)
						r.key_index = 8'($urandom_range(223, 160));
					if ($urandom_range(4) != 0)
						r.key_down = !tracker.key_state[r.key_index];
				end
				send_request(r);
				if (r.req_type != REQ_NONE)
					issued++;
			end
		end
		req_valid <= 1'b0;

		// Drain outstanding events, then let the pipeline settle
		while (tracker.events_due.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);

		if (tracker.mismatches == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule

`default_nettype wire
